/* src/der_csl_pkg.sv */
// ----------------------------------------------------------------------------
// DER certificate span locator package
// Shared item and result types and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package der_csl_pkg;

  // Width of the reported offset and length fields.
  localparam int LEN_W = 24;

  // Most long-form length octets a header may carry.
  localparam int MAX_LENGTH_OCTETS = 3;

  // One input item: a certificate byte and its end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] span_offset;
    logic [LEN_W-1:0] span_length;
  } result_t;

endpackage

`default_nettype wire

/* src/der_certificate_span_locator.sv */
// ----------------------------------------------------------------------------
// DER certificate span locator
// Streams a DER certificate and reports the offset and length of the whole
// certificate or of its SubjectPublicKeyInfo.
// ----------------------------------------------------------------------------
// The block takes one certificate byte per cycle and gives one result item
// on the byte marked last. An accepted byte is held in the input register,
// the header parser handles it from there, and the verdict is loaded into
// the result register when the parser takes the last byte. A byte per
// cycle is sustained; the input stalls only while a finished result waits
// in the result register and the byte to be parsed is another last byte.
// Writing the mode through cfg_we (only while idle) also restarts the
// parser.
`default_nettype none

module der_certificate_span_locator #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [23:0]      span_offset,
  output logic [23:0]      span_length
);

  der_csl_pkg::item_t   item;
  der_csl_pkg::result_t res;
  der_csl_pkg::result_t out_res;
  logic item_valid;
  logic take;
  logic res_valid;
  logic out_free;

  // A last byte is parsed only when its result has a place to go.
  assign take = item_valid && (!item.last_byte || out_free);

  der_csl_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  der_csl_parser #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  der_csl_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign found       = out_res.found;
  assign span_offset = out_res.span_offset;
  assign span_length = out_res.span_length;

endmodule

`default_nettype wire

/* src/der_csl_in_stage.sv */
// ----------------------------------------------------------------------------
// Input stage
// Registers one accepted item and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module der_csl_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic              take,
  output logic                   item_valid,
  output der_csl_pkg::item_t     item
);

  logic accept;

  // The stage frees up in the same cycle that the parser takes its item.
  assign in_stall = item_valid && !take;
  assign accept   = in_valid && !in_stall;

  // Valid bit of the holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // Payload is loaded on acceptance only.
  always_ff @(posedge clk) begin
    if (accept) begin
      item.data_byte <= data_byte;
      item.last_byte <= last_byte;
    end
  end

endmodule

`default_nettype wire

/* src/der_csl_parser.sv */
// ----------------------------------------------------------------------------
// DER header parser
// Walks tag, length and content of each element, one byte per cycle while
// bytes are taken, and produces the span verdict on the last byte of a certificate.
// ----------------------------------------------------------------------------
`default_nettype none

module der_csl_parser #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_data,
  input  wire logic                 take,
  input  wire der_csl_pkg::item_t   item,
  output logic                      res_valid,
  output der_csl_pkg::result_t      res
);

  localparam int PB    = POSITION_BITS;
  localparam int LW    = der_csl_pkg::LEN_W;
  localparam int SUM_W = ((PB + 1 > LW) ? PB + 1 : LW) + 1;
  localparam logic [PB-1:0] POS_MAX = '1;

  // Element being parsed.
  localparam logic [3:0] STEP_CERT    = 4'd0;
  localparam logic [3:0] STEP_TBS     = 4'd1;
  localparam logic [3:0] STEP_VERSION = 4'd2;
  localparam logic [3:0] STEP_SERIAL  = 4'd3;
  localparam logic [3:0] STEP_SPKI    = 4'd8;

  // Expected tag numbers.
  localparam logic [31:0] TAG_SEQUENCE = 32'h10;
  localparam logic [31:0] TAG_VERSION  = 32'h00;
  localparam logic [31:0] TAG_INTEGER  = 32'h02;

  typedef enum logic [4:0] {
    PH_TAG  = 5'b00001,
    PH_TAGX = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_LENX = 5'b01000,
    PH_SKIP = 5'b10000
  } phase_t;

  logic           mode;
  logic [PB-1:0]  pos, pos_next;
  logic [3:0]     step, step_next, step_tag;
  phase_t         phase, phase_next;
  logic [31:0]    tag, tag_next, tag_cand, tag_exp;
  logic           cons, cons_next;
  logic [LW-1:0]  acc, acc_next, len_cand;
  logic [1:0]     lleft, lleft_next;
  logic [LW-1:0]  skip, skip_next;
  logic [PB-1:0]  hstart, hstart_next;
  logic [PB-1:0]  loff, loff_next;
  logic [PB-1:0]  llen, llen_next;
  logic [PB:0]    span_end, span_end_next;
  logic           err, err_next;
  logic           done, done_next;
  logic           tag_end, hdr_end, take_err;
  logic [SUM_W-1:0] total;
  logic [7:0]     b;
  logic           trail_ok, found;

  assign b = item.data_byte;

  // Header plus content length of the element whose header ends now.
  assign total = SUM_W'(pos) + SUM_W'(1) - SUM_W'(hstart) + SUM_W'(len_cand);

  // Next state for one byte.
  always_comb begin
    pos_next      = pos;
    step_next     = step;
    phase_next    = phase;
    tag_next      = tag;
    cons_next     = cons;
    acc_next      = acc;
    lleft_next    = lleft;
    skip_next     = skip;
    hstart_next   = hstart;
    loff_next     = loff;
    llen_next     = llen;
    span_end_next = span_end;
    done_next     = done;
    tag_cand      = tag;
    len_cand      = acc;
    tag_end       = 1'b0;
    hdr_end       = 1'b0;
    take_err      = 1'b0;
    step_tag      = step;
    tag_exp       = TAG_SEQUENCE;

    if (!err && !done) begin
      unique case (phase)
        PH_TAG: begin
          hstart_next = pos;
          cons_next   = b[5];
          if (b[4:0] == 5'h1f) begin
            tag_next   = '0;
            phase_next = PH_TAGX;
          end else begin
            tag_cand = {27'd0, b[4:0]};
            tag_next = tag_cand;
            tag_end  = 1'b1;
          end
        end
        PH_TAGX: begin
          tag_cand = {tag[24:0], b[6:0]};
          tag_next = tag_cand;
          tag_end  = !b[7];
        end
        PH_LEN: begin
          if (cons && b == 8'h80) begin
            take_err = 1'b1;
          end else if (!b[7]) begin
            len_cand = LW'(b);
            acc_next = len_cand;
            hdr_end  = 1'b1;
          end else if (b[6:0] > 7'(der_csl_pkg::MAX_LENGTH_OCTETS)) begin
            take_err = 1'b1;
          end else begin
            len_cand   = '0;
            acc_next   = '0;
            lleft_next = b[1:0];
            if (b[1:0] == 2'd0) begin
              hdr_end = 1'b1;
            end else begin
              phase_next = PH_LENX;
            end
          end
        end
        PH_LENX: begin
          len_cand   = {acc[LW-9:0], b};
          acc_next   = len_cand;
          lleft_next = lleft - 2'd1;
          hdr_end    = (lleft == 2'd1);
        end
        PH_SKIP: begin
          skip_next = skip - LW'(1);
          if (skip == LW'(1)) begin
            phase_next = PH_TAG;
          end
        end
        default: begin
          take_err = 1'b1;
        end
      endcase
    end

    // Tag finished: an optional version that is absent falls to the serial.
    if (tag_end) begin
      if (step == STEP_VERSION && tag_cand != 32'd0) begin
        step_tag = STEP_SERIAL;
      end
      if (step_tag == STEP_VERSION) begin
        tag_exp = TAG_VERSION;
      end else if (step_tag == STEP_SERIAL) begin
        tag_exp = TAG_INTEGER;
      end
      step_next = step_tag;
      if (tag_cand != tag_exp) begin
        take_err = 1'b1;
      end else begin
        phase_next = PH_LEN;
      end
    end

    // Header finished: measure the span, enter the element, or skip it.
    if (hdr_end) begin
      if ((step == STEP_CERT && !mode) || step == STEP_SPKI) begin
        if (total > SUM_W'(POS_MAX)) begin
          take_err = 1'b1;
        end else begin
          loff_next     = hstart;
          llen_next     = PB'(total);
          span_end_next = (PB+1)'(total + SUM_W'(hstart));
          done_next     = 1'b1;
        end
      end else if (step <= STEP_TBS) begin
        step_next  = step + 4'd1;
        phase_next = PH_TAG;
      end else begin
        step_next = step + 4'd1;
        if (len_cand == '0) begin
          phase_next = PH_TAG;
        end else begin
          skip_next  = len_cand;
          phase_next = PH_SKIP;
        end
      end
    end

    // Position counts every byte but the last; overflow is an error.
    err_next = err || take_err;
    if (!item.last_byte) begin
      if (pos >= POS_MAX) begin
        err_next = 1'b1;
      end else begin
        pos_next = pos + PB'(1);
      end
    end
  end

  // Verdict on the last byte. A span measured on this very byte always
  // ends past the current position.
  assign trail_ok  = done && ({1'b0, pos} >= span_end);
  assign found     = !err_next && done_next && (!mode || trail_ok);
  assign res_valid = take && item.last_byte;

  always_comb begin
    res.found       = found;
    res.span_offset = found ? LW'(loff_next) : '0;
    res.span_length = found ? LW'(llen_next) : '0;
  end

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_we) begin
      mode <= cfg_data;
    end
  end

  // Parser state; cleared by reset, a mode write, or the end of a certificate.
  always_ff @(posedge clk) begin
    if (rst || cfg_we || (take && item.last_byte)) begin
      pos      <= '0;
      step     <= STEP_CERT;
      phase    <= PH_TAG;
      tag      <= '0;
      cons     <= 1'b0;
      acc      <= '0;
      lleft    <= '0;
      skip     <= '0;
      hstart   <= '0;
      loff     <= '0;
      llen     <= '0;
      span_end <= '0;
      err      <= 1'b0;
      done     <= 1'b0;
    end else if (take) begin
      pos      <= pos_next;
      step     <= step_next;
      phase    <= phase_next;
      tag      <= tag_next;
      cons     <= cons_next;
      acc      <= acc_next;
      lleft    <= lleft_next;
      skip     <= skip_next;
      hstart   <= hstart_next;
      loff     <= loff_next;
      llen     <= llen_next;
      span_end <= span_end_next;
      err      <= err_next;
      done     <= done_next;
    end
  end

endmodule

`default_nettype wire

/* src/der_csl_out_stage.sv */
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds a verdict until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module der_csl_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  res_valid,
  input  wire der_csl_pkg::result_t  res,
  output logic                       out_free,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output der_csl_pkg::result_t       out_res
);

  // The register can load when empty or when its item leaves this cycle.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

/* bench/der_certificate_span_locator_checker.sv */
// ----------------------------------------------------------------------------
// DER certificate span locator checker
// Watches the byte, result and configuration ports of the span locator,
// tracks the certificate parse in step with the block and compares every
// result item with the span it should report.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Tag numbers and octet codes shared by the checker and the stimulus.
package der_csl_bench_pkg;

  localparam logic [31:0] TAG_SEQUENCE = 32'h10;
  localparam logic [31:0] TAG_VERSION  = 32'h00;
  localparam logic [31:0] TAG_INTEGER  = 32'h02;

  // Low five tag bits that announce a multi-octet tag number.
  localparam logic [4:0] TAG_LONG_FORM = 5'h1f;

  // Length octet of an indefinite length.
  localparam logic [7:0] LEN_INDEFINITE = 8'h80;

endpackage

module der_certificate_span_locator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        found,
  input  logic [23:0] span_offset,
  input  logic [23:0] span_length,
  output int          failures,
  output int          pending
);

  // Where the parser stands inside the current header.
  typedef enum logic [2:0] {
    HDR_TAG,
    HDR_TAG_MORE,
    HDR_LEN,
    HDR_LEN_MORE,
    HDR_SKIP
  } hdr_phase_t;

  // Elements walked on the way to the public key info.
  localparam logic [3:0] ELEM_CERT    = 4'd0;
  localparam logic [3:0] ELEM_TBS     = 4'd1;
  localparam logic [3:0] ELEM_VERSION = 4'd2;
  localparam logic [3:0] ELEM_SERIAL  = 4'd3;
  localparam logic [3:0] ELEM_SPKI    = 4'd8;

  localparam logic [23:0] POS_MAX = {der_csl_pkg::LEN_W{1'b1}};

  logic                cur_mode;
  logic [23:0]         at_byte;
  logic [3:0]          elem_step;
  hdr_phase_t          hdr_phase;
  logic [31:0]         tag_val;
  logic                is_constructed;
  logic [23:0]         len_val;
  logic [1:0]          len_octets;
  logic [23:0]         skip_count;
  logic [23:0]         hdr_start_pos;
  logic [23:0]         span_off;
  logic [23:0]         span_len;
  logic                saw_error;
  logic                span_found;

  der_csl_pkg::result_t expected_spans[$];

  task automatic restart_parse();
    at_byte        = '0;
    elem_step      = ELEM_CERT;
    hdr_phase      = HDR_TAG;
    tag_val        = '0;
    is_constructed = 1'b0;
    len_val        = '0;
    len_octets     = '0;
    skip_count     = '0;
    hdr_start_pos  = '0;
    span_off       = '0;
    span_len       = '0;
    saw_error      = 1'b0;
    span_found     = 1'b0;
  endtask

  function automatic logic [31:0] wanted_tag();
    if (elem_step == ELEM_VERSION) begin
      return der_csl_bench_pkg::TAG_VERSION;
    end
    if (elem_step == ELEM_SERIAL) begin
      return der_csl_bench_pkg::TAG_INTEGER;
    end
    return der_csl_bench_pkg::TAG_SEQUENCE;
  endfunction

  // The header ends on this byte: measure it, enter it or skip its content.
  task automatic close_header();
    logic [25:0] total;
    total = {2'b00, at_byte} + 26'd1 - {2'b00, hdr_start_pos} + {2'b00, len_val};
    if ((elem_step == ELEM_CERT && !cur_mode) || elem_step == ELEM_SPKI) begin
      if (total > {2'b00, POS_MAX}) begin
        saw_error = 1'b1;
      end else begin
        span_off   = hdr_start_pos;
        span_len   = total[23:0];
        span_found = 1'b1;
      end
    end else if (elem_step <= ELEM_TBS) begin
      elem_step = elem_step + 4'd1;
      hdr_phase = HDR_TAG;
    end else begin
      elem_step = elem_step + 4'd1;
      if (len_val == '0) begin
        hdr_phase = HDR_TAG;
      end else begin
        skip_count = len_val;
        hdr_phase  = HDR_SKIP;
      end
    end
  endtask

  // A missing version lets its tag stand in for the serial number.
  task automatic close_tag();
    if (elem_step == ELEM_VERSION && tag_val != der_csl_bench_pkg::TAG_VERSION) begin
      elem_step = ELEM_SERIAL;
    end
    if (tag_val != wanted_tag()) begin
      saw_error = 1'b1;
    end else begin
      hdr_phase = HDR_LEN;
    end
  endtask

  task automatic parse_octet(input logic [7:0] b);
    case (hdr_phase)
      HDR_TAG: begin
        hdr_start_pos  = at_byte;
        is_constructed = b[5];
        if (b[4:0] == der_csl_bench_pkg::TAG_LONG_FORM) begin
          tag_val   = '0;
          hdr_phase = HDR_TAG_MORE;
        end else begin
          tag_val = {27'd0, b[4:0]};
          close_tag();
        end
      end
      HDR_TAG_MORE: begin
        tag_val = {tag_val[24:0], b[6:0]};
        if (!b[7]) begin
          close_tag();
        end
      end
      HDR_LEN: begin
        if (is_constructed && b == der_csl_bench_pkg::LEN_INDEFINITE) begin
          saw_error = 1'b1;
        end else if (!b[7]) begin
          len_val = {16'd0, b};
          close_header();
        end else if (b[6:0] > der_csl_pkg::MAX_LENGTH_OCTETS) begin
          saw_error = 1'b1;
        end else begin
          len_val    = '0;
          len_octets = b[1:0];
          if (len_octets == 2'd0) begin
            close_header();
          end else begin
            hdr_phase = HDR_LEN_MORE;
          end
        end
      end
      HDR_LEN_MORE: begin
        len_val    = {len_val[15:0], b};
        len_octets = len_octets - 2'd1;
        if (len_octets == 2'd0) begin
          close_header();
        end
      end
      HDR_SKIP: begin
        skip_count = skip_count - 24'd1;
        if (skip_count == '0) begin
          hdr_phase = HDR_TAG;
        end
      end
      default: begin
        saw_error = 1'b1;
      end
    endcase
  endtask

  // Advance the parse by one byte; the last byte yields the expected span.
  task automatic predict_span(input logic [7:0] b, input logic is_last);
    der_csl_pkg::result_t span;
    logic ok;
    if (!saw_error && !span_found) begin
      parse_octet(b);
    end
    if (!is_last) begin
      if (at_byte >= POS_MAX) begin
        saw_error = 1'b1;
      end else begin
        at_byte = at_byte + 24'd1;
      end
    end else begin
      ok = !saw_error && span_found;
      // Public key info must end before the data does.
      if (ok && cur_mode &&
          ({1'b0, at_byte} < {1'b0, span_off} + {1'b0, span_len})) begin
        ok = 1'b0;
      end
      span.found       = ok;
      span.span_offset = ok ? span_off : '0;
      span.span_length = ok ? span_len : '0;
      expected_spans.push_back(span);
      restart_parse();
    end
  endtask

  // Sample all ports at the rising edge; predict first, then compare.
  always @(posedge clk) begin : watch
    der_csl_pkg::result_t want;
    if (rst) begin
      cur_mode = 1'b0;
      restart_parse();
      expected_spans.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        cur_mode = cfg_data;
        restart_parse();
      end
      if (in_valid && !in_stall) begin
        predict_span(data_byte, last_byte);
      end
      if (out_valid && !out_stall) begin
        if (expected_spans.size() == 0) begin
          if (failures < 10) begin
            $display("unexpected result item: found %0d offset %0d length %0d",
                     found, span_offset, span_length);
          end
          failures = failures + 1;
        end else begin
          want = expected_spans.pop_front();
          if (found !== want.found || span_offset !== want.span_offset ||
              span_length !== want.span_length) begin
            if (failures < 10) begin
              $display("span mismatch exp/got: found %0d/%0d offset %0d/%0d length %0d/%0d",
                       want.found, found, want.span_offset, span_offset,
                       want.span_length, span_length);
            end
            failures = failures + 1;
          end
        end
      end
    end
    pending = expected_spans.size();
  end

endmodule

/* bench/der_certificate_span_locator_test.sv */
// ----------------------------------------------------------------------------
// DER certificate span locator testbench
// Streams directed and random certificates, well formed and broken, in both
// span modes with random idling on both channels and one long result
// hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module der_certificate_span_locator_test;

  localparam int  HOLD_CYCLES   = 300;
  localparam int  DRAIN_CYCLES  = 8;
  localparam int  PHASE_BYTES   = 200;
  localparam int  PHASE_COUNT   = 6;
  localparam bit [5:0] PHASE_MODES = 6'b101101;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_data;
  logic        in_valid;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_stall;
  wire         in_stall;
  wire         out_valid;
  wire         found;
  wire  [23:0] span_offset;
  wire  [23:0] span_length;
  int          failures;
  int          pending;

  // Stimulus controls shared with the result side.
  bit          calm = 1'b0;
  bit          hold_wanted = 1'b0;
  bit          hold_started;
  int          hold_left;
  int          items_sent = 0;

  // Certificate under construction and where its public key info ends.
  logic [7:0]  stream_q[$];
  int          spki_end;

  always #2 clk = ~clk;

  der_certificate_span_locator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .span_offset (span_offset),
    .span_length (span_length)
  );

  der_certificate_span_locator_checker span_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .span_offset (span_offset),
    .span_length (span_length),
    .failures    (failures),
    .pending     (pending)
  );

  function automatic logic [7:0] rand_octet();
    return 8'($urandom);
  endfunction

  // Offer one item at the falling edge and hold it until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    @(negedge clk);
    while (!calm && $urandom_range(99, 0) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    last_byte = is_last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent = items_sent + 1;
  endtask

  // Send up to eight literal bytes, most significant first.
  task automatic send_run(input logic [63:0] bytes, input int count, input logic mark_last);
    int i;
    for (i = count - 1; i >= 0; i--) begin
      send_byte(bytes[8*i +: 8], mark_last && i == 0);
    end
  endtask

  task automatic send_stream();
    int i;
    for (i = 0; i < stream_q.size(); i++) begin
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
  endtask

  // Wait until every span has come back and the parser has gone quiet.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic mode);
    settle();
    cfg_we   = 1'b1;
    cfg_data = mode;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Tag in short or long form, with random class bits.
  task automatic put_tag(input logic [31:0] num, input logic cons);
    logic [1:0]  cls;
    logic [31:0] part;
    int          groups;
    int          g;
    cls = 2'($urandom_range(3, 0));
    if (num < 31 && $urandom_range(3, 0) != 0) begin
      stream_q.push_back({cls, cons, num[4:0]});
    end else begin
      stream_q.push_back({cls, cons, der_csl_bench_pkg::TAG_LONG_FORM});
      if ($urandom_range(3, 0) == 0) begin
        stream_q.push_back(8'h80);
      end
      groups = 1;
      while (groups < 5 && (num >> (7 * groups)) != 0) begin
        groups++;
      end
      for (g = groups - 1; g >= 0; g--) begin
        part = num >> (7 * g);
        stream_q.push_back({g != 0, part[6:0]});
      end
    end
  endtask

  // Length in short form, padded long form, or indefinite when primitive.
  task automatic put_len(input logic [31:0] len, input logic prim_ok);
    int         r;
    int         min_oct;
    int         k;
    logic [1:0] n_oct;
    r = $urandom_range(9, 0);
    if (len == 0 && prim_ok && r < 3) begin
      stream_q.push_back(der_csl_bench_pkg::LEN_INDEFINITE);
    end else if (len < 128 && r < 7) begin
      stream_q.push_back(len[7:0]);
    end else begin
      min_oct = (len < 256) ? 1 : ((len < 65536) ? 2 : 3);
      n_oct   = 2'($urandom_range(der_csl_pkg::MAX_LENGTH_OCTETS, min_oct));
      stream_q.push_back({6'b100000, n_oct});
      for (k = int'(n_oct) - 1; k >= 0; k--) begin
        stream_q.push_back(8'(len >> (8 * k)));
      end
    end
  endtask

  task automatic put_element(input logic [31:0] tag, input logic cons, input int count);
    put_tag(tag, cons);
    put_len(32'(count), !cons);
    repeat (count) stream_q.push_back(rand_octet());
  endtask

  // Declared lengths of the enclosing sequences, now and then huge.
  function automatic logic [31:0] wide_len();
    int r;
    r = $urandom_range(9, 0);
    if (r < 6) begin
      return 32'($urandom_range(400, 0));
    end
    if (r < 9) begin
      return 32'($urandom_range(70000, 0));
    end
    return 32'($urandom_range(24'hffffff, 0));
  endfunction

  // One certificate shaped for the parser, sometimes broken afterwards.
  task automatic build_cert();
    int kind;
    int cut;
    int idx;
    stream_q.delete();
    put_tag(der_csl_bench_pkg::TAG_SEQUENCE, 1'b1);
    put_len(wide_len(), 1'b0);
    put_tag(der_csl_bench_pkg::TAG_SEQUENCE, 1'b1);
    put_len(wide_len(), 1'b0);
    if ($urandom_range(9, 0) < 7) begin
      put_element(der_csl_bench_pkg::TAG_VERSION, 1'b1, $urandom_range(4, 0));
    end
    put_element(der_csl_bench_pkg::TAG_INTEGER, 1'b0, $urandom_range(8, 0));
    repeat (4) put_element(der_csl_bench_pkg::TAG_SEQUENCE,
                           $urandom_range(7, 0) != 0, $urandom_range(6, 0));
    put_element(der_csl_bench_pkg::TAG_SEQUENCE,
                $urandom_range(7, 0) != 0, $urandom_range(10, 0));
    spki_end = stream_q.size();
    repeat ($urandom_range(6, 1)) stream_q.push_back(rand_octet());

    kind = $urandom_range(99, 0);
    if (kind < 70) begin
      // Left well formed.
    end else if (kind < 78) begin
      cut = $urandom_range(stream_q.size(), 1);
      while (stream_q.size() > cut) begin
        void'(stream_q.pop_back());
      end
    end else if (kind < 86) begin
      idx = $urandom_range((stream_q.size() > 16) ? 15 : stream_q.size() - 1, 0);
      stream_q[idx] = rand_octet();
    end else if (kind < 92) begin
      // Data stops right where the public key info ends.
      while (stream_q.size() > spki_end) begin
        void'(stream_q.pop_back());
      end
    end else begin
      stream_q.delete();
      repeat ($urandom_range(12, 1)) stream_q.push_back(rand_octet());
    end
  endtask

  // Result side: random stalls, one long hold-off, and a calm stretch.
  initial begin
    out_stall    = 1'b0;
    hold_started = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left = hold_left - 1;
      end else if (hold_wanted && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES - 1;
        out_stall    = 1'b1;
      end else begin
        out_stall = !calm && ($urandom_range(99, 0) < 12);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int         ph;
    int         start_count;
    logic [7:0] rb;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Whole-certificate mode: header corner cases.
    set_mode(1'b0);
    send_run(64'hff, 1, 1'b1);
    send_run(64'h3000, 2, 1'b1);
    send_run(64'h0200, 2, 1'b1);
    send_run(64'h3080, 2, 1'b1);
    send_run(64'h3084, 2, 1'b1);
    send_run(64'h3083ffffff, 5, 1'b1);
    send_run(64'h3083fffffa, 5, 1'b1);
    send_run(64'h1f1080, 3, 1'b1);
    send_run(64'h3f81808080801000, 8, 1'b1);

    // A certificate cut short by a mode change.
    send_run(64'h300030, 3, 1'b0);
    set_mode(1'b1);

    // Key info mode: with a version and trailing data.
    send_run(64'h30003000a0000200, 8, 1'b0);
    send_run(64'h3000300030003000, 8, 1'b0);
    send_run(64'h300000, 3, 1'b1);
    // No version, key info running to the end of the data.
    send_run(64'h3000300002010530, 8, 1'b0);
    send_run(64'h0030003000300030, 8, 1'b0);
    send_run(64'h00, 1, 1'b1);
    // Last byte arrives inside skipped content.
    send_run(64'h30003000020501, 7, 1'b1);

    // Short certificates against a long result hold-off.
    set_mode(1'b0);
    hold_wanted = 1'b1;
    repeat (30) begin
      rb = rand_octet();
      send_run({48'd0, 8'h30, rb}, 2, 1'b1);
    end

    // Random certificates over several mode settings.
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      set_mode(PHASE_MODES[ph]);
      calm = (ph == 3);
      start_count = items_sent;
      while (items_sent - start_count < PHASE_BYTES) begin
        build_cert();
        send_stream();
      end
    end
    calm = 1'b0;

    settle();
    if (failures == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Give up well past the slowest correct run.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
src/der_csl_pkg.sv
src/der_csl_in_stage.sv
src/der_csl_parser.sv
src/der_csl_out_stage.sv
src/der_certificate_span_locator.sv
bench/der_certificate_span_locator_checker.sv
bench/der_certificate_span_locator_test.sv
